>>> hw/rtl/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared constants and types of the percentile contrast stretch unit.
// ----------------------------------------------------------------------------
package pcs_pkg;

	// Width of one histogram bin and of the pixel total.
	localparam int COUNT_BITS = 24;
	localparam int BINS       = 256;
	localparam int ADDR_W     = 8;
	localparam int PCT_W      = 7;
	// Cumulative sum over all bins and its product with a percentage.
	localparam int ACC_W      = COUNT_BITS + ADDR_W;
	localparam int PROD_W     = ACC_W + PCT_W;

	// Divider operand widths.
	localparam int NUM_W      = 16;
	localparam int DEN_W      = 8;

	// Input actions.
	localparam logic [1:0] ACT_COUNT = 2'd0;
	localparam logic [1:0] ACT_MAP   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Output levels of the curve knees.
	localparam logic [7:0] KNEE_OUT_LO = 8'd12;
	localparam logic [7:0] KNEE_OUT_HI = 8'd242;

	// Histogram memory access.
	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_W-1:0]     rd_addr;
		logic                  wr_en;
		logic [ADDR_W-1:0]     wr_addr;
		logic [COUNT_BITS-1:0] wr_data;
		logic                  clear;
	} hist_req_t;

endpackage

>>> hw/rtl/pcs_hist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_hist_mem
// Histogram bin memory with one read and one write port, registered read
// data and a valid bit per bin so that a clear takes effect at once.
// ----------------------------------------------------------------------------
module pcs_hist_mem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcs_pkg::hist_req_t             req,
	output logic [pcs_pkg::COUNT_BITS-1:0] rd_data
);

	logic [pcs_pkg::COUNT_BITS-1:0] mem_q [pcs_pkg::BINS];
	logic [pcs_pkg::BINS-1:0]       valid_q;
	logic [pcs_pkg::COUNT_BITS-1:0] data_q;
	logic                           hit_q;

	// Storage array and its registered read.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_q <= mem_q[req.rd_addr];
		end
	end

	// Valid bits: a bin that was never written since the last clear reads zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (req.rd_en) begin
				hit_q <= valid_q[req.rd_addr];
			end
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

>>> hw/rtl/pcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pcs_pkg::NUM_W-1:0] num,
	input  logic [pcs_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [pcs_pkg::NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(pcs_pkg::NUM_W + 1);

	logic [pcs_pkg::NUM_W-1:0] quo_q;
	logic [pcs_pkg::DEN_W:0]   rem_q;
	logic [pcs_pkg::DEN_W-1:0] den_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [pcs_pkg::DEN_W:0]   rem_sh;
	logic                      take;

	// One trial subtraction per cycle.
	assign rem_sh = {rem_q[pcs_pkg::DEN_W-1:0], quo_q[pcs_pkg::NUM_W-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(pcs_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[pcs_pkg::NUM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> hw/rtl/percentile_contrast_stretch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percentile_contrast_stretch_unit
// Two-pass percentile contrast stretch of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A count item adds to its histogram bin
// by a read-modify-write of the bin memory; a clear empties the histogram at
// once through per-bin valid bits. A map item runs the bit-serial divider
// that works out the curve segment; a pixel sitting on a common knee needs no
// division. The first map item after reset or a clear first scans all 256
// bins through the memory read port. A finished result waits in an output
// register while further items are taken in, and a map item waits at its end
// until that register is free.
module percentile_contrast_stretch_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // pixel
	input  logic [1:0]                    s_axis_tuser,  // action
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // mapped_pixel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [pcs_pkg::PCT_W-1:0]     cfg_data
);

	localparam int CB = pcs_pkg::COUNT_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CNT_WR = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_SETUP  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	localparam logic CFG_LOW  = 1'b0;
	localparam logic CFG_HIGH = 1'b1;

	logic [2:0]                      state_q;
	logic [pcs_pkg::PCT_W-1:0]       low_pct_q, high_pct_q;
	logic [CB-1:0]                   total_q;
	logic [7:0]                      lower_q, upper_q;
	logic                            ready_q;
	logic [7:0]                      pix_q;
	logic [7:0]                      offs_q;
	logic [7:0]                      res_q;
	logic                            out_valid_q;
	logic [7:0]                      out_data_q;

	logic [pcs_pkg::PROD_W-1:0]      goal_lo_q, goal_hi_q;
	logic [7:0]                      scan_q;
	logic                            scan_end_q;
	logic                            vld_s1, vld_s2;
	logic [7:0]                      idx_s1, idx_s2;
	logic [pcs_pkg::ACC_W-1:0]       acc_q;
	logic                            lo_found_q, hi_found_q;

	pcs_pkg::hist_req_t              hreq;
	logic [CB-1:0]                   rd_data;
	logic                            in_fire;
	logic                            div_start, div_done;
	logic [pcs_pkg::NUM_W-1:0]       div_num, div_quo;
	logic [pcs_pkg::DEN_W-1:0]       div_den;
	logic [pcs_pkg::PROD_W-1:0]      acc_x100;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	pcs_hist_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hreq),
		.rd_data (rd_data)
	);

	pcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Memory requests: count read, count write-back, scan reads and clear.
	always_comb begin
		hreq         = '0;
		hreq.wr_addr = pix_q;
		hreq.wr_data = (rd_data == {CB{1'b1}}) ? rd_data : rd_data + 1'b1;
		hreq.rd_addr = in_fire ? s_axis_tdata : scan_q;
		if (in_fire && s_axis_tuser == pcs_pkg::ACT_COUNT) begin
			hreq.rd_en = 1'b1;
		end
		if (state_q == ST_SCAN && !scan_end_q) begin
			hreq.rd_en = 1'b1;
		end
		if (state_q == ST_CNT_WR) begin
			hreq.wr_en = 1'b1;
		end
		if (in_fire && s_axis_tuser == pcs_pkg::ACT_CLEAR) begin
			hreq.clear = 1'b1;
		end
	end

	// Cumulative count times one hundred, as shifts and adds.
	assign acc_x100 = (pcs_pkg::PROD_W'(acc_q) << 6) + (pcs_pkg::PROD_W'(acc_q) << 5)
		+ (pcs_pkg::PROD_W'(acc_q) << 2);

	// Segment selection of the three-piece curve.
	always_comb begin
		div_num = '0;
		div_den = '1;
		if (pix_q < lower_q) begin
			div_num = 16'(pix_q) * 16'd12;
			div_den = lower_q;
		end else if (pix_q > upper_q) begin
			div_num = 16'(pix_q - upper_q) * 16'd13;
			div_den = 8'd255 - upper_q;
		end else begin
			div_num = 16'(pix_q - lower_q) * 16'd230;
			div_den = upper_q - lower_q;
		end
	end

	assign div_start = (state_q == ST_SETUP) && (lower_q != upper_q || pix_q < lower_q
		|| pix_q > upper_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_pct_q  <= 7'd5;
			high_pct_q <= 7'd95;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOW:  low_pct_q  <= cfg_data;
				CFG_HIGH: high_pct_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// Scan pipeline: read, accumulate, compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN) && !scan_end_q;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		idx_s2 <= idx_s1;
		if (state_q != ST_SCAN) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + pcs_pkg::ACC_W'(rd_data);
		end
	end

	// Main control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			lower_q     <= 8'd0;
			upper_q     <= 8'd255;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
			scan_q      <= '0;
			scan_end_q  <= 1'b0;
			lo_found_q  <= 1'b0;
			hi_found_q  <= 1'b0;
		end else begin
			// The output register loads a new result or empties when taken.
			if (state_q == ST_RESULT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (s_axis_tuser)
							pcs_pkg::ACT_COUNT: begin
								state_q <= ST_CNT_WR;
								if (total_q != {CB{1'b1}}) begin
									total_q <= total_q + 1'b1;
								end
							end
							pcs_pkg::ACT_MAP: begin
								if (ready_q) begin
									state_q <= ST_SETUP;
								end else begin
									state_q    <= ST_SCAN;
									scan_q     <= '0;
									scan_end_q <= 1'b0;
									lo_found_q <= 1'b0;
									hi_found_q <= 1'b0;
									lower_q    <= 8'd0;
									upper_q    <= 8'd255;
								end
							end
							pcs_pkg::ACT_CLEAR: begin
								total_q <= '0;
								lower_q <= 8'd0;
								upper_q <= 8'd255;
								ready_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_CNT_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (!scan_end_q) begin
						scan_q <= scan_q + 1'b1;
						if (scan_q == 8'd255) begin
							scan_end_q <= 1'b1;
						end
					end
					if (vld_s2) begin
						if (!lo_found_q && acc_x100 >= goal_lo_q) begin
							lo_found_q <= 1'b1;
							lower_q    <= idx_s2;
						end
						if (!hi_found_q && acc_x100 >= goal_hi_q) begin
							hi_found_q <= 1'b1;
							upper_q    <= idx_s2;
						end
						if (idx_s2 == 8'd255) begin
							ready_q <= 1'b1;
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					state_q <= div_start ? ST_DIV : ST_RESULT;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q     <= s_axis_tdata;
			goal_lo_q <= pcs_pkg::PROD_W'(low_pct_q) * pcs_pkg::PROD_W'(total_q);
			goal_hi_q <= pcs_pkg::PROD_W'(high_pct_q) * pcs_pkg::PROD_W'(total_q);
		end
		if (state_q == ST_SETUP) begin
			if (pix_q < lower_q) begin
				offs_q <= 8'd0;
			end else if (pix_q > upper_q) begin
				offs_q <= pcs_pkg::KNEE_OUT_HI;
			end else begin
				offs_q <= pcs_pkg::KNEE_OUT_LO;
			end
			res_q <= pcs_pkg::KNEE_OUT_LO;
		end
		if (state_q == ST_DIV && div_done) begin
			res_q <= div_quo[7:0] + offs_q;
		end
		if (state_q == ST_RESULT && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= res_q;
		end
	end

endmodule
